/* src/optimal_bst_cost_table_unit_defines.svh */
// Assertion macros for the optimal BST cost table unit.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef OPTIMAL_BST_COST_TABLE_UNIT_DEFINES_SVH
`define OPTIMAL_BST_COST_TABLE_UNIT_DEFINES_SVH
// Implication check, disabled in reset.
`define OBST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check, disabled in reset.
`define OBST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* src/obst_pkg.sv */
// Package for the optimal BST cost table unit: sizes, payload structs, states, saturating add.
// Depends on nothing.
`default_nettype none
package obst_pkg;
	localparam int unsigned MaxKeysDef    = 8;
	localparam int unsigned WeightBitsDef = 8;
	localparam int unsigned CostBits      = 16;
	localparam logic [CostBits-1:0] CostMax = 16'hFFFF;

	typedef struct packed {
		logic [7:0] key_weight;
		logic [7:0] miss_weight;
		logic       final_pair;
	} obst_in_t;

	typedef struct packed {
		logic [3:0]  row_start;
		logic [3:0]  col_end;
		logic [15:0] expected_cost;
		logic [3:0]  best_root;
		logic        overflowed;
		logic        last_entry;
	} obst_out_t;

	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_INIT  = 9'b000000010,
		ST_WGT   = 9'b000000100,
		ST_RDA   = 9'b000001000,
		ST_RDB   = 9'b000010000,
		ST_ACC   = 9'b000100000,
		ST_WRC   = 9'b001000000,
		ST_EMIT  = 9'b010000000,
		ST_EMITW = 9'b100000000
	} obst_state_t;

	function automatic logic [CostBits-1:0] sat_add(input logic [CostBits-1:0] a,
			input logic [CostBits-1:0] b);
		logic [CostBits:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CostBits] ? CostMax : s[CostBits-1:0];
	endfunction
endpackage
`default_nettype wire

/* src/optimal_bst_cost_table_unit.sv */
// Top level of the optimal BST cost table unit: loader, sequencer, shared adder.
// Depends on obst_pkg, obst_ram and the assertion macro header.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------
//   in       | in  | in_valid/in_ready  | obst_in_t
//   out      | out | out_valid/out_ready| obst_out_t
//
// A non-final pair is stored and counted. A final pair starts the table build; one
// saturating adder serves the weight sums and cost writes. Seeding the diagonal
// writes one cell per row (n+1). Each cell then reads and adds its weight (WGT),
// makes two RAM reads and an add and compare per candidate root (RDA, RDB, ACC)
// and one write (WRC), paced by the single RAM read port. Emission reads, then
// offers, each cell (EMIT, EMITW). in_ready is low from the final pair until the
// last cell has been taken; a stalled out_ready holds the sequencer.
// Reset clears control state only; the tables need no clearing.
`default_nettype none
`include "optimal_bst_cost_table_unit_defines.svh"
module optimal_bst_cost_table_unit
	import obst_pkg::*;
#(
	parameter int unsigned MAX_KEYS    = MaxKeysDef,
	parameter int unsigned WEIGHT_BITS = WeightBitsDef
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire obst_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output obst_out_t      out_data
);
	localparam int unsigned Dim   = MAX_KEYS + 1;
	localparam int unsigned Cells = Dim * Dim;
	localparam int unsigned AW    = $clog2(Cells);
	localparam int unsigned KW    = $clog2(Dim + 1);

	obst_state_t state_q;
	logic [KW-1:0] cnt_q, n_q, i_q, j_q, r_q, len_q;
	logic          ovf_q;
	logic [7:0]    hit_q [Dim];
	logic [7:0]    miss_q [Dim];
	logic [CostBits-1:0] acc_q, best_q, wcell_q;
	logic [3:0]    broot_q;
	logic          have_q;
	logic          tmp_q;
	logic          in_acc, out_acc;

	// table RAMs
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [CostBits-1:0] c_wd, c_rd, w_wd, w_rd;
	logic [3:0]         r_wd, r_rd;

	obst_ram #(.Width(CostBits), .Depth(Cells)) u_cost (
		.clk, .we, .waddr, .wdata(c_wd), .raddr, .rdata(c_rd));
	obst_ram #(.Width(CostBits), .Depth(Cells)) u_wgt (
		.clk, .we, .waddr, .wdata(w_wd), .raddr, .rdata(w_rd));
	obst_ram #(.Width(4), .Depth(Cells)) u_root (
		.clk, .we, .waddr, .wdata(r_wd), .raddr, .rdata(r_rd));

	function automatic logic [AW-1:0] cell_addr(input logic [KW-1:0] i, input logic [KW-1:0] j);
		logic [AW+KW:0] a;
		a = ({{(AW+1){1'b0}}, i} - 1'b1) * (AW+KW+1)'(Dim) + {{(AW+1){1'b0}}, j};
		return a[AW-1:0];
	endfunction

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMITW);

	logic [KW-1:0] jj;
	assign jj = i_q + len_q - 1'b1;

	// shared adder input selection
	logic [CostBits-1:0] add_a, add_b, add_s;
	always_comb begin
		add_a = acc_q;
		add_b = c_rd;
		if (state_q == ST_WGT) begin
			add_a = w_rd;
			add_b = CostBits'({8'd0, hit_q[jj[KW-1:0]]}) + CostBits'({8'd0, miss_q[jj]});
		end else if (state_q == ST_WRC) begin
			add_a = best_q;
			add_b = wcell_q;
		end
	end
	assign add_s = sat_add(add_a, add_b);

	// RAM address and write control
	always_comb begin
		we    = 1'b0;
		waddr = cell_addr(i_q, j_q);
		c_wd  = add_s;
		w_wd  = wcell_q;
		r_wd  = broot_q;
		raddr = cell_addr(i_q, jj - 1'b1);
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = cell_addr(i_q, i_q - 1'b1);
				c_wd  = CostBits'(miss_q[i_q - 1'b1]);
				w_wd  = CostBits'(miss_q[i_q - 1'b1]);
				r_wd  = '0;
			end
			ST_RDA:  raddr = cell_addr(i_q, r_q - 1'b1);
			ST_RDB:  raddr = cell_addr(r_q + 1'b1, jj);
			ST_WRC: begin
				we    = 1'b1;
				waddr = cell_addr(i_q, jj);
			end
			ST_EMIT, ST_EMITW: raddr = cell_addr(i_q, j_q);
			default: ;
		endcase
	end

	logic [7:0] kw_m, mw_m;
	assign kw_m = in_data.key_weight  & 8'((1 << WEIGHT_BITS) - 1);
	assign mw_m = in_data.miss_weight & 8'((1 << WEIGHT_BITS) - 1);

	always_ff @(posedge clk) begin
		if (in_acc && cnt_q < KW'(Dim)) begin
			hit_q[cnt_q[KW-1:0]]  <= kw_m;
			miss_q[cnt_q[KW-1:0]] <= mw_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			r_q     <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			best_q  <= '0;
			wcell_q <= '0;
			broot_q <= '0;
			have_q  <= 1'b0;
			tmp_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						logic [KW-1:0] held;
						held = (cnt_q < KW'(Dim)) ? cnt_q + 1'b1 : cnt_q;
						if (cnt_q >= KW'(Dim)) ovf_q <= 1'b1;
						if (in_data.final_pair) begin
							// no keys: drop and restart with the count still at zero
							if (held != KW'(1)) begin
								n_q     <= held - 1'b1;
								i_q     <= KW'(1);
								state_q <= ST_INIT;
							end
						end else if (cnt_q < KW'(Dim)) begin
							cnt_q <= held;
						end
					end
				end
				ST_INIT: begin
					// seed the diagonal, rows 1..n+1
					if (i_q == n_q + 1'b1) begin
						len_q   <= KW'(1);
						i_q     <= KW'(1);
						state_q <= ST_WGT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_WGT: begin
					// w_rd was read last cycle at (i, j-1); allow read latency
					if (tmp_q) begin
						wcell_q <= add_s;
						r_q     <= i_q;
						have_q  <= 1'b0;
						tmp_q   <= 1'b0;
						state_q <= ST_RDA;
					end else begin
						tmp_q <= 1'b1;
					end
				end
				ST_RDA: begin
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					acc_q   <= c_rd;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// c_rd now holds e(r+1,j); add_s = e(i,r-1) + e(r+1,j) (unsaturated compare)
					logic [CostBits:0] s;
					s = {1'b0, acc_q} + {1'b0, c_rd};
					if (!have_q || s < {1'b0, best_q} || (best_q == CostMax && !s[CostBits] &&
							s[CostBits-1:0] < CostMax)) begin
						best_q  <= s[CostBits] ? CostMax : s[CostBits-1:0];
						broot_q <= 4'(r_q);
						have_q  <= 1'b1;
					end
					if (r_q == jj) state_q <= ST_WRC;
					else begin
						r_q     <= r_q + 1'b1;
						state_q <= ST_RDA;
					end
				end
				ST_WRC: begin
					// advance cell
					if (jj == n_q) begin
						if (len_q == n_q) begin
							i_q     <= KW'(1);
							j_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							len_q   <= len_q + 1'b1;
							i_q     <= KW'(1);
							state_q <= ST_WGT;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_WGT;
					end
				end
				ST_EMIT: begin
					state_q <= ST_EMITW;
				end
				ST_EMITW: begin
					if (out_acc) begin
						if (j_q == n_q) begin
							if (i_q == n_q) begin
								cnt_q   <= '0;
								ovf_q   <= 1'b0;
								state_q <= ST_LOAD;
							end else begin
								i_q     <= i_q + 1'b1;
								j_q     <= i_q;
								state_q <= ST_EMIT;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// saturated sums: if best is already saturated, ties stay with the smaller root
	always_comb begin
		out_data.row_start     = 4'(i_q);
		out_data.col_end       = 4'(j_q);
		out_data.expected_cost = c_rd;
		out_data.best_root     = r_rd;
		out_data.overflowed    = ovf_q;
		out_data.last_entry    = (i_q == n_q) && (j_q == n_q);
	end

	`OBST_ASSERT_IMP(a_no_in_busy, clk, arst_n, state_q != ST_LOAD, !in_ready, "input taken while busy")
	`OBST_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= KW'(Dim), "pair count beyond capacity")
	`OBST_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	`OBST_ASSERT_IMP(a_root_range, clk, arst_n, out_valid && out_data.col_end >= out_data.row_start, out_data.best_root >= out_data.row_start && out_data.best_root <= out_data.col_end, "root outside subrange")
endmodule
`default_nettype wire

/* src/obst_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module obst_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 81
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
